[src/sbtp_pkg.sv]
package sbtp_pkg;

  localparam int DATA_W          = 32;
  localparam int SPAN_WORDS_DEF  = 128;

  localparam logic [DATA_W-1:0] MASK_ALL  = 32'hffff_ffff;
  localparam logic [DATA_W-1:0] MASK_BYTE = 32'h0000_00ff;

  typedef enum logic [1:0] {
    REG_TEST = 2'd0,
    REG_MODE = 2'd1,
    REG_ADDR = 2'd2,
    REG_DATA = 2'd3
  } reg_sel_t;

  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } buf_ctl_t;

  function automatic logic [DATA_W-1:0] col_mask(input logic [1:0] col);
    logic [DATA_W-1:0] m;
    case (col)
      2'd0, 2'd1: m = MASK_ALL;
      2'd2:       m = MASK_BYTE;
      default:    m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [DATA_W-1:0] merge(input logic [DATA_W-1:0] old,
                                               input logic [DATA_W-1:0] val,
                                               input logic [DATA_W-1:0] mask);
    return (old & ~mask) | (val & mask);
  endfunction

endpackage

[src/sbtp_buffer.sv]
module sbtp_buffer
  import sbtp_pkg::*;
#(
  parameter int SPAN_WORDS = SPAN_WORDS_DEF,
  localparam int ADDR_W = $clog2(SPAN_WORDS)
) (
  input  logic              clk,
  input  logic              rst,
  input  buf_ctl_t          ctl,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata,
  output logic              clearing
);

  logic [DATA_W-1:0] mem [SPAN_WORDS];
  logic [ADDR_W-1:0] clr_addr;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(SPAN_WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

[src/sbtp_regs.sv]
module sbtp_regs
  import sbtp_pkg::*;
#(
  parameter int SPAN_WORDS = SPAN_WORDS_DEF,
  localparam int ADDR_W = $clog2(SPAN_WORDS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              req_type,
  input  logic [1:0]        reg_index,
  input  logic [DATA_W-1:0] write_data,
  input  logic [DATA_W-1:0] write_mask,
  output buf_ctl_t          ctl,
  output logic [ADDR_W-1:0] buf_addr,
  output logic [DATA_W-1:0] buf_wdata,
  input  logic [DATA_W-1:0] buf_rdata,
  output logic              done,
  output logic [DATA_W-1:0] read_data
);

  logic [DATA_W-1:0] test_reg;
  logic [DATA_W-1:0] mode_reg;
  logic [ADDR_W-1:0] addr_reg;
  logic [DATA_W-1:0] data_reg;

  logic [DATA_W-1:0] addr_ext;
  logic [DATA_W-1:0] sel_old;
  logic [DATA_W-1:0] merged;
  logic [DATA_W-1:0] cur_col;
  logic              is_write;
  logic              is_data;

  logic              res_buf;
  logic [DATA_W-1:0] res_val;
  logic [DATA_W-1:0] res_col;

  assign is_write = (req_type == REQ_WRITE);
  assign is_data  = (reg_index == REG_DATA);
  assign addr_ext = DATA_W'(addr_reg);
  assign cur_col  = col_mask(addr_reg[1:0]);

  always_comb begin
    unique case (reg_index)
      REG_TEST: sel_old = test_reg;
      REG_MODE: sel_old = mode_reg;
      REG_ADDR: sel_old = addr_ext;
      REG_DATA: sel_old = data_reg;
      default:  sel_old = '0;
    endcase
  end

  assign merged = merge(sel_old, write_data, write_mask);

  assign ctl.wr    = accept && is_write && is_data && mode_reg[0];
  assign ctl.rd    = accept && !is_write && is_data;
  assign buf_addr  = addr_reg;
  assign buf_wdata = merged & cur_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      test_reg <= '0;
      mode_reg <= '0;
      addr_reg <= '0;
      data_reg <= '0;
      done     <= 1'b0;
    end else begin
      done <= accept;
      if (accept && is_write) begin
        unique case (reg_index)
          REG_TEST: test_reg <= merged;
          REG_MODE: mode_reg <= merged;
          REG_ADDR: addr_reg <= merged[ADDR_W-1:0];
          REG_DATA: data_reg <= merged;
          default:  test_reg <= test_reg;
        endcase
      end
    end
  end

  // result stage, the buffer word comes registered from the read
  always_ff @(posedge clk) begin
    if (accept) begin
      res_buf <= !is_write && is_data && mode_reg[0];
      res_col <= cur_col;
      if (is_write || is_data) begin
        res_val <= '0;
      end else begin
        res_val <= sel_old;
      end
    end
  end

  assign read_data = res_buf ? (buf_rdata & res_col) : res_val;

endmodule

[src/span_buffer_test_port_top.sv]
// channel   | signals                                         | handshake
// ----------+-------------------------------------------------+---------------------
// request   | req_type, reg_index, write_data, write_mask     | start && !busy
// result    | read_data                                       | done, one cycle
//
// one request per cycle when not busy; done strobes the cycle after acceptance
// the buffer memory is read at acceptance and its registered word feeds read_data
// after reset busy stays high while the buffer is zeroed
// results cannot be held off; done is never stalled and busy only covers the clear
module span_buffer_test_port_top
  import sbtp_pkg::*;
#(
  parameter int SPAN_WORDS = SPAN_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              req_type,
  input  logic [1:0]        reg_index,
  input  logic [DATA_W-1:0] write_data,
  input  logic [DATA_W-1:0] write_mask,
  output logic              done,
  output logic [DATA_W-1:0] read_data
);

  localparam int ADDR_W = $clog2(SPAN_WORDS);

  buf_ctl_t          ctl;
  logic [ADDR_W-1:0] buf_addr;
  logic [DATA_W-1:0] buf_wdata;
  logic [DATA_W-1:0] buf_rdata;
  logic              clearing;
  logic              accept;

  assign busy   = clearing;
  assign accept = start && !clearing;

  sbtp_regs #(.SPAN_WORDS(SPAN_WORDS)) u_regs (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req_type   (req_type),
    .reg_index  (reg_index),
    .write_data (write_data),
    .write_mask (write_mask),
    .ctl        (ctl),
    .buf_addr   (buf_addr),
    .buf_wdata  (buf_wdata),
    .buf_rdata  (buf_rdata),
    .done       (done),
    .read_data  (read_data)
  );

  sbtp_buffer #(.SPAN_WORDS(SPAN_WORDS)) u_buffer (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .addr     (buf_addr),
    .wdata    (buf_wdata),
    .rdata    (buf_rdata),
    .clearing (clearing)
  );

endmodule

[src/sbtp_checker.sv]
module sbtp_checker
  import sbtp_pkg::*;
#(
  parameter int SPAN_WORDS = SPAN_WORDS_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              req_type,
  input logic [1:0]        reg_index,
  input logic              done,
  input logic [DATA_W-1:0] read_data
);

  // every accepted beat gives exactly one result the next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted beat without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without accepted beat");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_WRITE) |=> (read_data == '0))
    else $error("write result not zero");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_READ && reg_index == REG_ADDR)
      |=> (read_data < DATA_W'(SPAN_WORDS)))
    else $error("address read beyond buffer");

  // once the clear is over the port stays open until the next reset
  a_busy_once: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !busy)
    else $error("busy raised outside reset");

endmodule

bind span_buffer_test_port_top sbtp_checker #(.SPAN_WORDS(SPAN_WORDS)) u_sbtp_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .req_type  (req_type),
  .reg_index (reg_index),
  .done      (done),
  .read_data (read_data)
);

[tb/sv/span_buffer_test_port_checker.sv]
`timescale 1ns / 100ps

module span_buffer_test_port_checker
  import sbtp_pkg::*;
#(
  parameter int SPAN_WORDS = SPAN_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic              req_type,
  input  logic [1:0]        reg_index,
  input  logic [DATA_W-1:0] write_data,
  input  logic [DATA_W-1:0] write_mask,
  input  logic              done,
  input  logic [DATA_W-1:0] read_data,
  output int                pending,
  output int                fail_count
);

  localparam int AW = $clog2(SPAN_WORDS);

  logic [DATA_W-1:0] span_mem [SPAN_WORDS];
  logic [DATA_W-1:0] test_q;
  logic [DATA_W-1:0] mode_q;
  logic [DATA_W-1:0] data_q;
  logic [AW-1:0]     addr_q;
  logic [DATA_W-1:0] read_q [$];

  initial begin
    fail_count = 0;
  end

  function automatic logic [DATA_W-1:0] lane_keep(input logic [1:0] col);
    logic [DATA_W-1:0] k;
    case (col)
      2'd0, 2'd1: k = MASK_ALL;
      2'd2:       k = MASK_BYTE;
      default:    k = '0;
    endcase
    return k;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    $display("mismatch at %0t: %s, expected %h, got %h", $realtime, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin : model
    logic [DATA_W-1:0] want;
    logic [DATA_W-1:0] merged;
    if (rst) begin
      for (int i = 0; i < SPAN_WORDS; i++) span_mem[i] = '0;
      test_q = '0;
      mode_q = '0;
      data_q = '0;
      addr_q = '0;
      read_q.delete();
    end else begin
      if (done) begin
        if (read_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", '0, read_data);
        end else begin
          want = read_q.pop_front();
          if (read_data !== want) report_mismatch("read_data", want, read_data);
        end
      end
      if (start && !busy) begin
        want = '0;
        if (req_kind_t'(req_type) == REQ_WRITE) begin
          case (reg_sel_t'(reg_index))
            REG_TEST: test_q = (test_q & ~write_mask) | (write_data & write_mask);
            REG_MODE: mode_q = (mode_q & ~write_mask) | (write_data & write_mask);
            REG_ADDR: begin
              merged = ({{(DATA_W-AW){1'b0}}, addr_q} & ~write_mask)
                       | (write_data & write_mask);
              addr_q = merged[AW-1:0];
            end
            default: begin
              data_q = (data_q & ~write_mask) | (write_data & write_mask);
              if (mode_q[0]) span_mem[addr_q] = data_q & lane_keep(addr_q[1:0]);
            end
          endcase
        end else begin
          case (reg_sel_t'(reg_index))
            REG_TEST: want = test_q;
            REG_MODE: want = mode_q;
            REG_ADDR: want = {{(DATA_W-AW){1'b0}}, addr_q};
            default:  want = mode_q[0] ? (span_mem[addr_q] & lane_keep(addr_q[1:0])) : '0;
          endcase
        end
        read_q.push_back(want);
      end
    end
    pending <= read_q.size();
  end

endmodule

[tb/sv/span_buffer_test_port_top_tb.sv]
`timescale 1ns / 100ps

module span_buffer_test_port_top_tb;
  import sbtp_pkg::*;

  localparam int SPAN_WORDS = SPAN_WORDS_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_ITEMS = 600;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              req_type = 1'b0;
  logic [1:0]        reg_index = '0;
  logic [DATA_W-1:0] write_data = '0;
  logic [DATA_W-1:0] write_mask = '0;
  logic              done;
  logic [DATA_W-1:0] read_data;

  int pending;
  int fail_count;
  int idle_cycles = 0;
  int issued = 0;
  int burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  span_buffer_test_port_top #(
    .SPAN_WORDS(SPAN_WORDS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .reg_index  (reg_index),
    .write_data (write_data),
    .write_mask (write_mask),
    .done       (done),
    .read_data  (read_data)
  );

  span_buffer_test_port_checker #(
    .SPAN_WORDS(SPAN_WORDS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .reg_index  (reg_index),
    .write_data (write_data),
    .write_mask (write_mask),
    .done       (done),
    .read_data  (read_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [DATA_W-1:0] pick_mask();
    logic [DATA_W-1:0] m;
    case ($urandom_range(0, 5))
      0:       m = MASK_ALL;
      1:       m = '0;
      2:       m = MASK_BYTE;
      default: m = $urandom;
    endcase
    return m;
  endfunction

  // one request beat; burst/gap pacing happens after acceptance
  task automatic issue_request(input req_kind_t kind, input reg_sel_t sel,
                               input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] m);
    start      <= 1'b1;
    req_type   <= kind;
    reg_index  <= sel;
    write_data <= d;
    write_mask <= m;
    do @(posedge clk); while (busy);
    issued++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset values, data read with test mode off
    issue_request(REQ_READ,  REG_TEST, '0, '0);
    issue_request(REQ_READ,  REG_MODE, '0, '0);
    issue_request(REQ_READ,  REG_ADDR, '0, '0);
    issue_request(REQ_READ,  REG_DATA, '0, '0);
    issue_request(REQ_WRITE, REG_TEST, MASK_ALL, MASK_ALL);
    issue_request(REQ_READ,  REG_TEST, '0, '0);
    issue_request(REQ_WRITE, REG_TEST, '0, 32'h0000_ffff);
    issue_request(REQ_READ,  REG_TEST, '0, '0);
    issue_request(REQ_WRITE, REG_MODE, 32'h0000_0001, MASK_ALL);
    issue_request(REQ_READ,  REG_MODE, '0, '0);
    // address wraps past the buffer end
    issue_request(REQ_WRITE, REG_ADDR, MASK_ALL, MASK_ALL);
    issue_request(REQ_READ,  REG_ADDR, '0, '0);
    // column 3 stores nothing
    issue_request(REQ_WRITE, REG_DATA, MASK_ALL, MASK_ALL);
    issue_request(REQ_READ,  REG_DATA, '0, '0);
    // column 2 keeps the low byte
    issue_request(REQ_WRITE, REG_ADDR, 32'h0000_0002, MASK_ALL);
    issue_request(REQ_WRITE, REG_DATA, 32'ha5a5_a5a5, MASK_ALL);
    issue_request(REQ_READ,  REG_DATA, '0, '0);
    issue_request(REQ_WRITE, REG_ADDR, 32'h0000_0001, MASK_ALL);
    issue_request(REQ_WRITE, REG_DATA, 32'h5a5a_5a5a, '0);
    issue_request(REQ_READ,  REG_DATA, '0, '0);
    // data write with test mode off leaves the buffer alone
    issue_request(REQ_WRITE, REG_MODE, '0, 32'h0000_0001);
    issue_request(REQ_WRITE, REG_DATA, 32'h1234_5678, MASK_ALL);
    issue_request(REQ_READ,  REG_DATA, '0, '0);
    issue_request(REQ_WRITE, REG_MODE, MASK_ALL, MASK_ALL);
    issue_request(REQ_READ,  REG_DATA, '0, '0);

    drain_results();
    issued = 0;

    while (issued < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          issue_request(REQ_WRITE, REG_MODE, $urandom | 32'd1, pick_mask() | 32'd1);
          issue_request(REQ_WRITE, REG_ADDR, $urandom,
                        ($urandom_range(0, 2) == 0) ? pick_mask() : MASK_ALL);
          issue_request(REQ_WRITE, REG_DATA, $urandom, pick_mask());
          issue_request(REQ_READ,  REG_DATA, $urandom, $urandom);
        end
        3, 4: begin
          issue_request(REQ_WRITE, REG_ADDR, $urandom, MASK_ALL);
          issue_request(REQ_READ,  REG_DATA, $urandom, $urandom);
        end
        5: begin
          issue_request(REQ_WRITE, REG_MODE, $urandom, pick_mask());
        end
        6: begin
          reg_sel_t sel;
          sel = reg_sel_t'($urandom_range(0, 3));
          issue_request(REQ_WRITE, sel, $urandom, pick_mask());
          issue_request(REQ_READ,  sel, $urandom, $urandom);
        end
        7: begin
          if ($urandom_range(0, 3) == 0) drain_results();
          issue_request(req_kind_t'($urandom_range(0, 1)), reg_sel_t'($urandom_range(0, 3)),
                        $urandom, $urandom);
        end
        default: begin
          issue_request(req_kind_t'($urandom_range(0, 1)), reg_sel_t'($urandom_range(0, 3)),
                        $urandom, pick_mask());
        end
      endcase
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
